### sv/scba_pkg.sv
`default_nettype none

package scba_pkg;

    // Size classes and region geometry
    localparam int NUM_ORDERS       = 24;
    localparam int BLOCKS_PER_ORDER = 1024;
    localparam int ORD_W     = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
    localparam int IDX_W     = $clog2(BLOCKS_PER_ORDER);
    localparam int BLK_W     = $clog2(BLOCKS_PER_ORDER + 1);
    localparam int LINK_DEPTH = NUM_ORDERS * BLOCKS_PER_ORDER;
    localparam int LINK_AW   = $clog2(LINK_DEPTH);

    localparam logic [63:0] REGION_BASE = 64'hFFFF_C000_0000_0000;
    localparam int REGION_SHIFT = 39;
    localparam int MIN_SHIFT    = 3;
    localparam int MIN_BYTES    = 8;
    localparam int OFF_IDX_W    = REGION_SHIFT - MIN_SHIFT;

    // Field widths
    localparam int ACT_W  = 2;
    localparam int SIZE_W = 32;
    localparam int ADDR_W = 64;
    localparam int ST_W   = 2;
    localparam int COPY_W = 28;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REALLOC = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd2;

    // Decoded request handed from the decoder to the list controller
    typedef struct packed {
        logic                 do_alloc;
        logic                 do_free;
        logic                 keep;
        logic                 too_large;
        logic [ORD_W-1:0]     new_ord;
        logic [ORD_W-1:0]     old_ord;
        logic [OFF_IDX_W-1:0] old_idx;
        logic [COPY_W-1:0]    copy;
        logic [ADDR_W-1:0]    keep_addr;
    } t_dec;

    // Position of the highest set bit plus one (priority encoder)
    function automatic logic [5:0] top_bit_plus1(input logic [SIZE_W-1:0] v);
        logic [5:0] lg;
        lg = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (v[i]) begin
                lg = 6'(i + 1);
            end
        end
        return lg;
    endfunction

    // Blocks available in one order: min(BLOCKS_PER_ORDER, 2^(36-o))
    function automatic logic [BLK_W-1:0] order_cap(input logic [ORD_W-1:0] o);
        logic [OFF_IDX_W:0] fit;
        fit = {{OFF_IDX_W{1'b0}}, 1'b1} << (OFF_IDX_W - int'(o));
        if (fit < (OFF_IDX_W + 1)'(BLOCKS_PER_ORDER)) begin
            return fit[BLK_W-1:0];
        end
        return BLK_W'(BLOCKS_PER_ORDER);
    endfunction

    // Byte address of block idx in order o
    function automatic logic [ADDR_W-1:0] block_addr(input logic [ORD_W-1:0] o,
                                                     input logic [IDX_W-1:0] idx);
        return REGION_BASE + (ADDR_W'(o) << REGION_SHIFT)
               + (ADDR_W'(idx) << (int'(o) + MIN_SHIFT));
    endfunction

    // Link memory address of block idx in order o
    function automatic logic [LINK_AW-1:0] link_addr(input logic [ORD_W-1:0] o,
                                                     input logic [IDX_W-1:0] idx);
        return LINK_AW'(o) * LINK_AW'(BLOCKS_PER_ORDER) + LINK_AW'(idx);
    endfunction

endpackage

`default_nettype wire

### sv/scba_ram.sv
`default_nettype none

module scba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/scba_decode.sv
`default_nettype none

module scba_decode (
    input  wire logic [scba_pkg::ACT_W-1:0]  i_action,
    input  wire logic [scba_pkg::SIZE_W-1:0] i_size,
    input  wire logic [scba_pkg::ADDR_W-1:0] i_addr,
    output scba_pkg::t_dec                   o_dec
);

    localparam int QUOT_W = scba_pkg::ADDR_W - scba_pkg::REGION_SHIFT;

    logic [scba_pkg::SIZE_W-1:0]    s_min;
    logic [scba_pkg::SIZE_W-1:0]    s_m1;
    logic [5:0]                     lg;
    logic [5:0]                     raw_ord;
    logic                           too_large;
    logic [scba_pkg::ADDR_W-1:0]    off;
    logic [QUOT_W-1:0]              quot;
    logic                           in_region;
    logic [scba_pkg::ORD_W-1:0]     old_ord;
    logic [scba_pkg::OFF_IDX_W-1:0] old_idx;
    logic                           have;
    logic                           fits;
    logic [scba_pkg::COPY_W-1:0]    old_bytes;

    // Round the request up to a power of two, at least the minimum block
    assign s_min = (i_size < scba_pkg::SIZE_W'(scba_pkg::MIN_BYTES)) ?
                   scba_pkg::SIZE_W'(scba_pkg::MIN_BYTES) : i_size;
    assign s_m1      = s_min - 1'b1;
    assign lg        = scba_pkg::top_bit_plus1(s_m1);
    assign raw_ord   = lg - 6'(scba_pkg::MIN_SHIFT);
    assign too_large = raw_ord >= 6'(scba_pkg::NUM_ORDERS);

    // Split the address into order and block index
    assign off       = i_addr - scba_pkg::REGION_BASE;
    assign quot      = off[scba_pkg::ADDR_W-1:scba_pkg::REGION_SHIFT];
    assign in_region = quot < QUOT_W'(scba_pkg::NUM_ORDERS);
    assign old_ord   = quot[scba_pkg::ORD_W-1:0];
    assign old_idx   = scba_pkg::OFF_IDX_W'(off[scba_pkg::REGION_SHIFT-1:0]
                       >> (int'(old_ord) + scba_pkg::MIN_SHIFT));
    assign have      = (i_addr != '0) && in_region;

    // Request fits the old block when its order is not above the old one
    assign fits      = raw_ord <= 6'(old_ord);
    assign old_bytes = scba_pkg::COPY_W'(1) << (int'(old_ord) + scba_pkg::MIN_SHIFT);

    // Work out which list operations the item needs
    always_comb begin
        o_dec           = '0;
        o_dec.too_large = too_large;
        o_dec.new_ord   = raw_ord[scba_pkg::ORD_W-1:0];
        o_dec.old_ord   = old_ord;
        o_dec.old_idx   = old_idx;
        o_dec.keep_addr = i_addr;
        unique case (i_action)
            scba_pkg::ACT_ALLOC: begin
                o_dec.do_alloc = 1'b1;
            end
            scba_pkg::ACT_FREE: begin
                o_dec.do_free = have;
            end
            scba_pkg::ACT_REALLOC: begin
                if (i_size == '0) begin
                    o_dec.do_free = have;
                end else if (have && fits) begin
                    o_dec.keep = 1'b1;
                end else begin
                    o_dec.do_alloc = 1'b1;
                    o_dec.do_free  = have;
                    o_dec.copy     = have ? old_bytes : '0;
                end
            end
            default: begin
                o_dec.keep_addr = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/scba_list_ctrl.sv
`default_nettype none

module scba_list_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire scba_pkg::t_dec              i_dec,
    input  wire logic                        i_m_tready,
    output logic                             o_idle,
    output logic                             o_m_tvalid,
    output logic [scba_pkg::ADDR_W-1:0]      o_res_addr,
    output logic [scba_pkg::ST_W-1:0]        o_status,
    output logic [scba_pkg::COPY_W-1:0]      o_copy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_FREE  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                    r_state;
    scba_pkg::t_dec                r_dec;
    logic [scba_pkg::BLK_W-1:0]    r_head [scba_pkg::NUM_ORDERS];
    logic [scba_pkg::BLK_W-1:0]    r_bump [scba_pkg::NUM_ORDERS];
    logic [scba_pkg::ADDR_W-1:0]   r_res;
    logic [scba_pkg::ST_W-1:0]     r_status;
    logic                          r_ovalid;
    logic [scba_pkg::ADDR_W-1:0]   r_oaddr;
    logic [scba_pkg::ST_W-1:0]     r_ostatus;
    logic [scba_pkg::COPY_W-1:0]   r_ocopy;

    logic [scba_pkg::BLK_W-1:0]    head_n;
    logic [scba_pkg::BLK_W-1:0]    head_m1;
    logic [scba_pkg::BLK_W-1:0]    bump_n;
    logic [scba_pkg::BLK_W-1:0]    cap_n;
    logic [scba_pkg::IDX_W-1:0]    pop_idx;
    logic [scba_pkg::IDX_W-1:0]    alloc_idx;
    logic                          can_bump;
    logic                          alloc_live;
    logic [scba_pkg::BLK_W-1:0]    head_o;
    logic [scba_pkg::BLK_W-1:0]    bump_o;
    logic [scba_pkg::IDX_W-1:0]    free_idx;
    logic                          free_go;
    logic                          load_out;
    logic                          ram_we;
    logic [scba_pkg::LINK_AW-1:0]  ram_addr;
    logic [scba_pkg::BLK_W-1:0]    ram_rdata;

    // Allocation side: list head and bump count of the requested order
    assign alloc_live = r_dec.do_alloc && !r_dec.too_large;
    assign head_n     = r_head[r_dec.new_ord];
    assign bump_n     = r_bump[r_dec.new_ord];
    assign cap_n      = scba_pkg::order_cap(r_dec.new_ord);
    assign head_m1    = head_n - 1'b1;
    assign pop_idx    = (head_m1 >= scba_pkg::BLK_W'(scba_pkg::BLOCKS_PER_ORDER)) ?
                        '0 : head_m1[scba_pkg::IDX_W-1:0];
    assign can_bump   = bump_n < cap_n;
    assign alloc_idx  = (head_n != '0) ? pop_idx : bump_n[scba_pkg::IDX_W-1:0];

    // Free side: push only blocks already handed out, and only if the item's alloc, if any, succeeded
    assign head_o   = r_head[r_dec.old_ord];
    assign bump_o   = r_bump[r_dec.old_ord];
    assign free_idx = r_dec.old_idx[scba_pkg::IDX_W-1:0];
    assign free_go  = r_dec.do_free
                      && (!r_dec.do_alloc || (r_status == scba_pkg::ST_OK))
                      && (r_dec.old_idx < scba_pkg::OFF_IDX_W'(bump_o));

    // Link memory: pop read in the alloc step, push write in the free step
    assign ram_we   = (r_state == S_FREE) && free_go;
    assign ram_addr = (r_state == S_ALLOC) ?
                      scba_pkg::link_addr(r_dec.new_ord, pop_idx) :
                      scba_pkg::link_addr(r_dec.old_ord, free_idx);

    scba_ram #(
        .WIDTH (scba_pkg::BLK_W),
        .DEPTH (scba_pkg::LINK_DEPTH)
    ) u_link (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (head_o),
        .o_rdata (ram_rdata)
    );

    assign load_out = (r_state == S_DONE) && (!r_ovalid || i_m_tready);

    // Sequencer, list heads, bump counts and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int k = 0; k < scba_pkg::NUM_ORDERS; k++) begin
                r_head[k] <= '0;
                r_bump[k] <= '0;
            end
        end else begin
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_ALLOC;
                    end
                end
                S_ALLOC: begin
                    if (alloc_live && (head_n != '0)) begin
                        r_state <= S_POP;
                    end else begin
                        if (alloc_live && can_bump) begin
                            r_bump[r_dec.new_ord] <= bump_n + 1'b1;
                        end
                        r_state <= S_FREE;
                    end
                end
                S_POP: begin
                    r_head[r_dec.new_ord] <= ram_rdata;
                    r_state <= S_FREE;
                end
                S_FREE: begin
                    if (free_go) begin
                        r_head[r_dec.old_ord] <= scba_pkg::BLK_W'(free_idx) + 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Item payload: decoded request, result and output register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_start) begin
            r_dec <= i_dec;
        end
        if (r_state == S_ALLOC) begin
            if (!r_dec.do_alloc) begin
                r_res    <= r_dec.keep ? r_dec.keep_addr : '0;
                r_status <= scba_pkg::ST_OK;
            end else if (r_dec.too_large) begin
                r_res    <= '0;
                r_status <= scba_pkg::ST_TOO_LARGE;
            end else if ((head_n != '0) || can_bump) begin
                r_res    <= scba_pkg::block_addr(r_dec.new_ord, alloc_idx);
                r_status <= scba_pkg::ST_OK;
            end else begin
                r_res    <= '0;
                r_status <= scba_pkg::ST_EXHAUSTED;
            end
        end
        if (load_out) begin
            r_oaddr   <= r_res;
            r_ostatus <= r_status;
            r_ocopy   <= (r_status == scba_pkg::ST_OK) ? r_dec.copy : '0;
        end
    end

    assign o_idle     = r_state == S_IDLE;
    assign o_m_tvalid = r_ovalid;
    assign o_res_addr = r_oaddr;
    assign o_status   = r_ostatus;
    assign o_copy     = r_ocopy;

endmodule

`default_nettype wire

### sv/size_class_block_allocator_core.sv
// Power-of-two size-class block allocator, 24 orders from 8 bytes up to 64 MiB.
// Input stream: tuser carries the action (allocate, free, reallocate), tdata
// the request size and the block address. Output stream: tdata carries the
// granted address and the byte count to copy, tuser the status. Every input
// item gives exactly one result item.
// Items are handled one at a time. After acceptance the item is decoded, the
// list head and bump count of its order are read, a pop reads the link memory,
// a push writes it, and the result is loaded into the output register.
// The single-port link memory is read, then written, for one item at a time; a new
// item is accepted only after the previous one is loaded into the output register.
// The output register holds a finished item while the receiver stalls; the
// next item is accepted and worked on meanwhile and waits only to be loaded.
// Reset empties all free lists and clears all bump counts at once; the link
// memory is not cleared, since a link is always written before it is read.
`default_nettype none

module size_class_block_allocator_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [95:0]  i_s_axis_tdata,  // request_size [31:0], block_address [95:32]
    input  wire logic [1:0]   i_s_axis_tuser,  // action [1:0]
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic      [95:0]  o_m_axis_tdata,  // result_address [63:0], copy_bytes [91:64], zero
    output logic      [1:0]   o_m_axis_tuser   // status [1:0]
);

    logic                          r_start;
    logic [scba_pkg::ACT_W-1:0]    r_action;
    logic [scba_pkg::SIZE_W-1:0]   r_size;
    logic [scba_pkg::ADDR_W-1:0]   r_addr;
    logic                          in_accept;
    logic                          ctrl_idle;
    scba_pkg::t_dec                dec;
    logic [scba_pkg::ADDR_W-1:0]   res_addr;
    logic [scba_pkg::ST_W-1:0]     status;
    logic [scba_pkg::COPY_W-1:0]   copy;

    assign o_s_axis_tready = ctrl_idle && !r_start;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // Capture an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action <= i_s_axis_tuser;
            r_size   <= i_s_axis_tdata[31:0];
            r_addr   <= i_s_axis_tdata[95:32];
        end
    end

    scba_decode u_decode (
        .i_action (r_action),
        .i_size   (r_size),
        .i_addr   (r_addr),
        .o_dec    (dec)
    );

    scba_list_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dec      (dec),
        .i_m_tready (i_m_axis_tready),
        .o_idle     (ctrl_idle),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_res_addr (res_addr),
        .o_status   (status),
        .o_copy     (copy)
    );

    assign o_m_axis_tdata = {4'b0, copy, res_addr};
    assign o_m_axis_tuser = status;

endmodule

`default_nettype wire

### sv/scba_checker.sv
`default_nettype none

module scba_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    input  wire logic         o_s_axis_tready,
    input  wire logic [95:0]  i_s_axis_tdata,
    input  wire logic [1:0]   i_s_axis_tuser,
    input  wire logic         o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    input  wire logic [95:0]  o_m_axis_tdata,
    input  wire logic [1:0]   o_m_axis_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // One item at a time: busy right after an acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("item accepted while previous item in flight");

    // No result straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A failed item grants nothing and copies nothing
    a_fail_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != scba_pkg::ST_OK)
        |-> (o_m_axis_tdata[63:0] == 64'd0) && (o_m_axis_tdata[91:64] == 28'd0))
        else $error("failed item carries an address or copy count");

    // A copy count comes only with a moved block
    a_copy_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[91:64] != 28'd0)
        |-> (o_m_axis_tdata[63:0] != 64'd0) && (o_m_axis_tdata[95:92] == 4'd0))
        else $error("copy count without a granted block");

endmodule

bind size_class_block_allocator_core scba_checker u_scba_checker (.*);

`default_nettype wire

### sim/tb_size_class_block_allocator_core.sv
`timescale 1ns / 1ps

// One granted item as it should leave the block
typedef struct packed {
    logic [scba_pkg::ADDR_W-1:0] addr;
    logic [scba_pkg::ST_W-1:0]   st;
    logic [scba_pkg::COPY_W-1:0] copy;
} t_alloc_grant;

// Base address of block idx in order o
function automatic logic [63:0] block_base(input int unsigned o, input logic [63:0] idx);
    return scba_pkg::REGION_BASE + (64'(o) << scba_pkg::REGION_SHIFT)
           + (idx << (o + scba_pkg::MIN_SHIFT));
endfunction

class grant_scoreboard;
    logic [10:0]  list_head[scba_pkg::NUM_ORDERS];
    logic [10:0]  handed_out[scba_pkg::NUM_ORDERS];
    logic [10:0]  link_mem[scba_pkg::LINK_DEPTH];
    t_alloc_grant awaited_grants[$];
    int           errors;

    function new();
        foreach (list_head[i]) begin
            list_head[i]  = '0;
            handed_out[i] = '0;
        end
        errors = 0;
    endfunction

    // Split an address into order and block index; false for a foreign address
    function bit locate(input logic [63:0] a, output int unsigned o, output logic [63:0] idx);
        logic [63:0] off;
        logic [63:0] q;
        off = a - scba_pkg::REGION_BASE;
        q   = off >> scba_pkg::REGION_SHIFT;
        o   = 0;
        idx = '0;
        if (q >= 64'(scba_pkg::NUM_ORDERS)) begin
            return 1'b0;
        end
        o   = int'(q);
        idx = (off & ((64'd1 << scba_pkg::REGION_SHIFT) - 64'd1)) >> (o + scba_pkg::MIN_SHIFT);
        return 1'b1;
    endfunction

    // Push a block onto its order's list; drop null, foreign and unissued blocks
    function void release_block(input logic [63:0] a);
        int unsigned o;
        logic [63:0] idx;
        if (a == '0 || !locate(a, o, idx)) begin
            return;
        end
        if (idx >= 64'(handed_out[o])) begin
            return;
        end
        link_mem[o * scba_pkg::BLOCKS_PER_ORDER + int'(idx)] = list_head[o];
        list_head[o] = 11'(idx + 1);
    endfunction

    // Pop the order's list or bump; return the status
    function logic [scba_pkg::ST_W-1:0] grab_block(input logic [31:0] sz,
                                                  output logic [63:0] a);
        logic [32:0] s;
        int unsigned lg;
        int unsigned o;
        logic [63:0] idx;
        logic [63:0] cap;
        s  = (sz < scba_pkg::MIN_BYTES) ? 33'(scba_pkg::MIN_BYTES) : 33'(sz);
        lg = 0;
        while (lg < 63 && (64'd1 << lg) < 64'(s)) begin
            lg++;
        end
        o = lg - scba_pkg::MIN_SHIFT;
        a = '0;
        if (o >= scba_pkg::NUM_ORDERS) begin
            return scba_pkg::ST_TOO_LARGE;
        end
        cap = 64'd1 << (scba_pkg::REGION_SHIFT - scba_pkg::MIN_SHIFT - o);
        if (cap > 64'(scba_pkg::BLOCKS_PER_ORDER)) begin
            cap = 64'(scba_pkg::BLOCKS_PER_ORDER);
        end
        if (list_head[o] != '0) begin
            idx = 64'(list_head[o]) - 64'd1;
            if (idx >= 64'(scba_pkg::BLOCKS_PER_ORDER)) begin
                idx = '0;
            end
            list_head[o] = link_mem[o * scba_pkg::BLOCKS_PER_ORDER + int'(idx)];
        end else if (64'(handed_out[o]) < cap) begin
            idx = 64'(handed_out[o]);
            handed_out[o] = handed_out[o] + 11'd1;
        end else begin
            return scba_pkg::ST_EXHAUSTED;
        end
        a = block_base(o, idx);
        return scba_pkg::ST_OK;
    endfunction

    // Work out the grant for an accepted request and queue it
    function t_alloc_grant note_request(input logic [1:0] act, input logic [31:0] sz,
                                        input logic [63:0] ptr);
        t_alloc_grant g;
        bit           have;
        int unsigned  o;
        logic [63:0]  idx;
        logic [63:0]  old_bytes;
        g    = '0;
        o    = 0;
        have = 1'b0;
        case (act)
            scba_pkg::ACT_ALLOC: begin
                g.st = grab_block(sz, g.addr);
            end
            scba_pkg::ACT_FREE: begin
                release_block(ptr);
            end
            scba_pkg::ACT_REALLOC: begin
                if (sz == '0) begin
                    release_block(ptr);
                end else begin
                    if (ptr != '0) begin
                        have = locate(ptr, o, idx);
                    end
                    old_bytes = have ? (64'd1 << (o + scba_pkg::MIN_SHIFT)) : 64'd0;
                    if (have && 64'(sz) <= old_bytes) begin
                        g.addr = ptr;
                    end else begin
                        g.st = grab_block(sz, g.addr);
                        if (g.st == scba_pkg::ST_OK && have) begin
                            release_block(ptr);
                            g.copy = old_bytes[scba_pkg::COPY_W-1:0];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        awaited_grants.push_back(g);
        return g;
    endfunction

    // Compare a delivered item with the oldest outstanding grant
    function void check_grant(input logic [63:0] addr, input logic [1:0] st,
                              input logic [27:0] copy);
        t_alloc_grant want;
        if (awaited_grants.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("unexpected item: addr %h status %0d copy %0d", addr, st, copy);
            end
            return;
        end
        want = awaited_grants.pop_front();
        if (want.addr !== addr || want.st !== st || want.copy !== copy) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch: addr exp %h got %h, status exp %0d got %0d, copy exp %0d got %0d",
                         want.addr, addr, want.st, st, want.copy, copy);
            end
        end
    endfunction
endclass

module tb_size_class_block_allocator_core;

    localparam logic [1:0]  ACT_UNDEF       = 2'd3;
    localparam logic [63:0] FOREIGN_ADDR    = scba_pkg::REGION_BASE
                                              + (64'(scba_pkg::NUM_ORDERS)
                                                 << scba_pkg::REGION_SHIFT);
    localparam int          ITEMS_PER_PHASE = 90;
    localparam int          HOLD_LEN        = 500;
    localparam int          CYCLE_LIMIT     = 1000000;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [95:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          hold_request   = 1'b0;
    int          hold_left      = 0;
    int          cycle_count    = 0;

    grant_scoreboard sb = new();
    logic [63:0]     live_blocks[$];

    size_class_block_allocator_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // request_size [31:0], block_address [95:32]
        .i_s_axis_tuser  (s_tuser),   // action [1:0]
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // result_address [63:0], copy_bytes [91:64], zero
        .o_m_axis_tuser  (m_tuser)    // status [1:0]
    );

    // Free-running clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up after a generous number of cycles
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Check every delivered item
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            sb.check_grant(m_tdata[63:0], m_tuser, m_tdata[91:64]);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [31:0] size_in_order(input int unsigned o);
        if (o == 0) begin
            return $urandom_range(scba_pkg::MIN_BYTES, 0);
        end
        return $urandom_range(32'd1 << (o + scba_pkg::MIN_SHIFT),
                              (32'd1 << (o + scba_pkg::MIN_SHIFT - 1)) + 1);
    endfunction

    // Mostly small orders, some of any order, some zero or arbitrary sizes
    function automatic logic [31:0] pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) begin
            return size_in_order($urandom_range(7));
        end else if (r < 90) begin
            return size_in_order($urandom_range(scba_pkg::NUM_ORDERS - 1));
        end else if (r < 95) begin
            return 32'd0;
        end
        return $urandom();
    endfunction

    function automatic int unsigned order_of(input logic [63:0] a);
        return int'((a - scba_pkg::REGION_BASE) >> scba_pkg::REGION_SHIFT);
    endfunction

    // Offer one item, wait for its acceptance, predict its grant
    task automatic send_item(input logic [1:0] act, input logic [31:0] sz,
                             input logic [63:0] ptr, output t_alloc_grant g);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ptr, sz};
        s_tuser  <= act;
        do @(posedge clk); while (!s_tready);
        g = sb.note_request(act, sz, ptr);
    endtask

    // Send and keep track of blocks newly handed out
    task automatic issue(input logic [1:0] act, input logic [31:0] sz,
                         input logic [63:0] ptr, output t_alloc_grant g);
        send_item(act, sz, ptr, g);
        if (act == scba_pkg::ACT_ALLOC && g.st == scba_pkg::ST_OK) begin
            live_blocks.push_back(g.addr);
        end else if (act == scba_pkg::ACT_REALLOC && g.st == scba_pkg::ST_OK
                     && g.addr != '0 && g.addr != ptr) begin
            live_blocks.push_back(g.addr);
        end
    endtask

    // Resize a live block; drop it from the list when it is freed or moved
    task automatic realloc_live(input logic [31:0] sz);
        int unsigned  k;
        logic [63:0]  a;
        t_alloc_grant g;
        k = $urandom_range(live_blocks.size() - 1);
        a = live_blocks[k];
        issue(scba_pkg::ACT_REALLOC, sz, a, g);
        if (sz == '0 || (g.st == scba_pkg::ST_OK && g.addr != a)) begin
            live_blocks.delete(k);
        end
    endtask

    // Malformed and unusual requests
    task automatic noise_item();
        int unsigned  k;
        int unsigned  o;
        logic [63:0]  a;
        t_alloc_grant g;
        o = $urandom_range(scba_pkg::NUM_ORDERS - 1);
        case ($urandom_range(7))
            0: issue(scba_pkg::ACT_ALLOC, $urandom(), rand64(), g);
            1: issue(scba_pkg::ACT_FREE, $urandom(), rand64(), g);
            2: issue(scba_pkg::ACT_REALLOC, $urandom(), rand64(), g);
            3: issue(ACT_UNDEF, $urandom(), rand64(), g);
            4: begin
                a = block_base(o, 64'(sb.handed_out[o]) + 64'($urandom_range(3)));
                issue(scba_pkg::ACT_FREE, $urandom(),
                      a | (rand64() & ((64'd1 << (o + scba_pkg::MIN_SHIFT)) - 1)), g);
            end
            5: issue(scba_pkg::ACT_REALLOC, pick_size(), FOREIGN_ADDR + 64'($urandom()), g);
            6: begin
                if (live_blocks.size() != 0) begin
                    k = $urandom_range(live_blocks.size() - 1);
                    a = live_blocks[k];
                    live_blocks.delete(k);
                    o = order_of(a);
                    issue(scba_pkg::ACT_FREE, $urandom(),
                          a | (rand64() & ((64'd1 << (o + scba_pkg::MIN_SHIFT)) - 1)), g);
                end else begin
                    issue(scba_pkg::ACT_FREE, $urandom(), 64'd0, g);
                end
            end
            default: begin
                // free without forgetting the block, so it may be freed a second time later
                if (live_blocks.size() != 0 && $urandom_range(3) == 0) begin
                    issue(scba_pkg::ACT_FREE, 32'd0,
                          live_blocks[$urandom_range(live_blocks.size() - 1)], g);
                end else begin
                    issue(scba_pkg::ACT_REALLOC, $urandom(), 64'd0, g);
                end
            end
        endcase
    endtask

    // Mostly well-formed allocate / free / resize traffic with some noise
    task automatic random_item();
        int unsigned  pick;
        int unsigned  k;
        logic [63:0]  a;
        t_alloc_grant g;
        pick = $urandom_range(99);
        if (pick < 80 && (pick < 35 || live_blocks.size() == 0)) begin
            issue(scba_pkg::ACT_ALLOC, pick_size(), rand64(), g);
        end else if (pick < 60) begin
            k = $urandom_range(live_blocks.size() - 1);
            a = live_blocks[k];
            live_blocks.delete(k);
            issue(scba_pkg::ACT_FREE, $urandom(), a, g);
        end else if (pick < 80) begin
            realloc_live(pick_size());
        end else begin
            noise_item();
        end
    endtask

    // Fill one order until it runs out, with the receiver held off at first
    task automatic fill_order_to_exhaustion();
        int unsigned  fo;
        int           extra;
        t_alloc_grant g;
        logic [63:0]  last_grant;
        fo = $urandom_range(scba_pkg::NUM_ORDERS - 1);
        for (int i = 0; i < scba_pkg::NUM_ORDERS && sb.list_head[fo] != '0; i++) begin
            fo = (fo + 1) % scba_pkg::NUM_ORDERS;
        end
        extra      = 0;
        last_grant = '0;
        hold_request = 1'b1;
        for (int n = 0; n < 1300 && extra < 4; n++) begin
            issue(scba_pkg::ACT_ALLOC, size_in_order(fo), rand64(), g);
            if (g.st == scba_pkg::ST_EXHAUSTED) begin
                extra++;
            end else if (g.st == scba_pkg::ST_OK) begin
                last_grant = g.addr;
            end
        end
        // resize into the full order fails unless the old block already fits; the old block is kept either way
        if (live_blocks.size() != 0) begin
            realloc_live(32'd1 << (fo + scba_pkg::MIN_SHIFT));
        end
        // hand one block back and take it again
        if (last_grant != '0) begin
            issue(scba_pkg::ACT_FREE, 32'd0, last_grant, g);
            issue(scba_pkg::ACT_ALLOC, size_in_order(fo), rand64(), g);
        end
    endtask

    initial begin
        t_alloc_grant g;
        t_alloc_grant g0;
        t_alloc_grant g1;
        t_alloc_grant g2;
        int           phase_send[4];
        int           phase_recv[4];

        phase_send = '{0, 67, 0, 7};
        phase_recv = '{0, 0, 67, 7};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: size rounding, limits, null and foreign addresses, resizing
        issue(scba_pkg::ACT_ALLOC, 32'd0, 64'd0, g0);
        issue(scba_pkg::ACT_ALLOC, 32'd8, 64'd0, g);
        issue(scba_pkg::ACT_ALLOC, 32'd9, 64'd0, g1);
        issue(scba_pkg::ACT_ALLOC, 32'h0400_0000, 64'd0, g);
        issue(scba_pkg::ACT_ALLOC, 32'h0400_0001, 64'd0, g);
        issue(scba_pkg::ACT_ALLOC, 32'hFFFF_FFFF, {64{1'b1}}, g);
        issue(scba_pkg::ACT_FREE, 32'd0, 64'd0, g);
        issue(scba_pkg::ACT_FREE, 32'd0, FOREIGN_ADDR, g);
        issue(scba_pkg::ACT_FREE, 32'hFFFF_FFFF, {64{1'b1}}, g);
        issue(scba_pkg::ACT_FREE, 32'd0, block_base(5, 64'd7), g);
        issue(scba_pkg::ACT_FREE, 32'd0, g0.addr | 64'd5, g);
        issue(scba_pkg::ACT_ALLOC, 32'd3, 64'd0, g);
        issue(scba_pkg::ACT_REALLOC, 32'd16, g1.addr, g);
        issue(scba_pkg::ACT_REALLOC, 32'd13, g1.addr, g);
        issue(scba_pkg::ACT_REALLOC, 32'd100, g1.addr, g2);
        issue(scba_pkg::ACT_REALLOC, 32'd40, FOREIGN_ADDR, g);
        issue(scba_pkg::ACT_REALLOC, 32'd8, 64'd0, g);
        issue(scba_pkg::ACT_REALLOC, 32'h0800_0000, g2.addr, g);
        issue(scba_pkg::ACT_REALLOC, 32'd0, g2.addr, g);
        issue(ACT_UNDEF, 32'hFFFF_FFFF, {64{1'b1}}, g);
        issue(scba_pkg::ACT_FREE, 32'd0, g0.addr, g);
        issue(scba_pkg::ACT_FREE, 32'd0, g0.addr, g);
        issue(scba_pkg::ACT_ALLOC, 32'd8, 64'd0, g);
        issue(scba_pkg::ACT_ALLOC, 32'd8, 64'd0, g);
        live_blocks.delete();

        // Random traffic under each idling pattern
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                random_item();
            end
        end

        // Back-pressure and running an order dry
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        fill_order_to_exhaustion();
        s_tvalid <= 1'b0;

        // Drain until every awaited grant has been checked, then let the bench settle
        recv_stall_pct = 0;
        while (sb.awaited_grants.size() != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
sv/scba_pkg.sv
sv/scba_ram.sv
sv/scba_decode.sv
sv/scba_list_ctrl.sv
sv/size_class_block_allocator_core.sv
sv/scba_checker.sv
sim/tb_size_class_block_allocator_core.sv
